// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/sfp_pkg.sv -----
// ----------------------------------------------------------------------------
// sfp_pkg
// Types and constants of the framed serial parser with CRC-16 check.
// ----------------------------------------------------------------------------
package sfp_pkg;

	localparam logic [15:0] CRC_POLY   = 16'h8005;
	localparam logic [7:0]  START_RST  = 8'h24;

	typedef enum logic [2:0] {
		PH_WAIT = 3'd0,
		PH_CMD  = 3'd1,
		PH_SIZE = 3'd2,
		PH_HSUM = 3'd3,
		PH_DATA = 3'd4,
		PH_CRC0 = 3'd5,
		PH_CRC1 = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		EV_DATA    = 2'd0,
		EV_GOOD    = 2'd1,
		EV_HDR_ERR = 2'd2,
		EV_CRC_ERR = 2'd3
	} ev_kind_t;

endpackage

// ----- rtl/core/sfp_rx_if.sv -----
// ----------------------------------------------------------------------------
// sfp_rx_if
// Received byte channel: valid/ready with one byte per request.
// ----------------------------------------------------------------------------
interface sfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/sfp_evt_if.sv -----
// ----------------------------------------------------------------------------
// sfp_evt_if
// Parser event channel: payload bytes and frame status.
// ----------------------------------------------------------------------------
interface sfp_evt_if
	import sfp_pkg::*;
;
	logic       valid;
	logic       ready;
	ev_kind_t   event_kind;
	logic [7:0] cmd_code;
	logic [7:0] payload_length;
	logic [7:0] byte_index;
	logic [7:0] byte_value;

	modport source (output valid, output event_kind, output cmd_code,
		output payload_length, output byte_index, output byte_value, input ready);
	modport sink   (input valid, input event_kind, input cmd_code,
		input payload_length, input byte_index, input byte_value, output ready);
endinterface

// ----- rtl/core/sfp_crc8.sv -----
// ----------------------------------------------------------------------------
// sfp_crc8
// One-byte CRC-16 update, polynomial 0x8005, data bits LSB first.
// ----------------------------------------------------------------------------
module sfp_crc8
	import sfp_pkg::*;
(
	input  logic [15:0] crc,
	input  logic [7:0]  data,
	output logic [15:0] crc_next
);

	always_comb begin
		logic [15:0] c;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			if (data[i] != c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_next = c;
	end

endmodule

// ----- rtl/core/serial_frame_parser_crc16_unit.sv -----
// ----------------------------------------------------------------------------
// serial_frame_parser_crc16_unit
// Hunts for the start byte, checks the header sum, passes payload bytes out
// with their index and checks the trailing CRC-16 of the frame.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                      | handshake
//  rx      | in  | rx_byte                                      | valid/ready
//  evt     | out | event_kind, cmd_code, payload_length,        | valid/ready
//          |     | byte_index, byte_value                       |
//  cfg     | in  | cfg_wdata (start byte)                       | cfg_we
//
//  One byte per cycle while rx.ready is high; a result is registered when its byte is taken.
//  The one-byte CRC update and the phase logic sit between the input
//  handshake and the event register.
//  rx.ready drops only while an event is held and evt.ready is low.
//  Reset: hunting for the start byte, start byte 0x24, no event pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_frame_parser_crc16_unit
	import sfp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata,
	sfp_rx_if.sink       rx,
	sfp_evt_if.source    evt
);

	phase_t      phase_q, phase_d;
	logic [7:0]  start_q;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_lo_q, crc_lo_d;

	logic        evt_valid_q;
	ev_kind_t    evt_kind_q, evt_kind_d;
	logic [7:0]  evt_cmd_q;
	logic [7:0]  evt_len_q;
	logic [7:0]  evt_idx_q, evt_idx_d;
	logic [7:0]  evt_val_q, evt_val_d;
	logic        emit_d;

	logic        rx_fire;
	logic [15:0] crc_upd;
	logic        hsum_ok;
	logic [7:0]  cnt_inc;

	assign rx.ready = !evt_valid_q || evt.ready;
	assign rx_fire  = rx.valid && rx.ready;
	assign hsum_ok  = (rx.rx_byte == 8'(cmd_q + len_q));
	assign cnt_inc  = cnt_q + 8'd1;

	sfp_crc8 u_crc (
		.crc      (crc_q),
		.data     (rx.rx_byte),
		.crc_next (crc_upd)
	);

	always_comb begin
		phase_d = phase_q;
		if (rx_fire) begin
			unique case (phase_q)
				PH_CMD:  phase_d = PH_SIZE;
				PH_SIZE: phase_d = PH_HSUM;
				PH_HSUM: begin
					if (!hsum_ok)
						phase_d = PH_WAIT;
					else if (len_q == 8'd0)
						phase_d = PH_CRC0;
					else
						phase_d = PH_DATA;
				end
				PH_DATA: begin
					if (cnt_inc == len_q)
						phase_d = PH_CRC0;
				end
				PH_CRC0: phase_d = PH_CRC1;
				PH_CRC1: phase_d = PH_WAIT;
				default: phase_d = (rx.rx_byte == start_q) ? PH_CMD : PH_WAIT;
			endcase
		end
	end

	always_comb begin
		cmd_d      = cmd_q;
		len_d      = len_q;
		cnt_d      = cnt_q;
		crc_d      = crc_q;
		crc_lo_d   = crc_lo_q;
		emit_d     = 1'b0;
		evt_kind_d = EV_DATA;
		evt_idx_d  = 8'd0;
		evt_val_d  = 8'd0;
		if (rx_fire) begin
			unique case (phase_q)
				PH_CMD: begin
					cmd_d = rx.rx_byte;
					crc_d = crc_upd;
				end
				PH_SIZE: begin
					len_d = rx.rx_byte;
					crc_d = crc_upd;
				end
				PH_HSUM: begin
					if (hsum_ok) begin
						crc_d = crc_upd;
						cnt_d = 8'd0;
					end else begin
						emit_d     = 1'b1;
						evt_kind_d = EV_HDR_ERR;
					end
				end
				PH_DATA: begin
					emit_d    = 1'b1;
					evt_idx_d = cnt_q;
					evt_val_d = rx.rx_byte;
					crc_d     = crc_upd;
					cnt_d     = cnt_inc;
				end
				PH_CRC0: crc_lo_d = rx.rx_byte;
				PH_CRC1: begin
					emit_d     = 1'b1;
					evt_kind_d = (crc_q == {rx.rx_byte, crc_lo_q}) ? EV_GOOD : EV_CRC_ERR;
				end
				default: begin
					if (rx.rx_byte == start_q)
						crc_d = 16'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT;
			start_q  <= START_RST;
			cmd_q    <= 8'd0;
			len_q    <= 8'd0;
			cnt_q    <= 8'd0;
			crc_q    <= 16'd0;
			crc_lo_q <= 8'd0;
		end else begin
			phase_q  <= phase_d;
			cmd_q    <= cmd_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
			if (cfg_we)
				start_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (rx.ready) begin
			evt_valid_q <= emit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && emit_d) begin
			evt_kind_q <= evt_kind_d;
			evt_cmd_q  <= cmd_q;
			evt_len_q  <= len_q;
			evt_idx_q  <= evt_idx_d;
			evt_val_q  <= evt_val_d;
		end
	end

	assign evt.valid          = evt_valid_q;
	assign evt.event_kind     = evt_kind_q;
	assign evt.cmd_code       = evt_cmd_q;
	assign evt.payload_length = evt_len_q;
	assign evt.byte_index     = evt_idx_q;
	assign evt.byte_value     = evt_val_q;

	`SFP_ASSERT_IMP(a_stall_blocks_rx, evt_valid_q && !evt.ready, !rx.ready, "rx taken while event held")
	`SFP_ASSERT_NXT(a_data_emits, rx_fire && phase_q == PH_DATA, evt_valid_q && evt_kind_q == EV_DATA, "payload byte lost")
	`SFP_ASSERT_NXT(a_start_clears, rx_fire && phase_q == PH_WAIT && rx.rx_byte == start_q, phase_q == PH_CMD && crc_q == 16'd0, "start byte not taken")
	`SFP_ASSERT_IMP(a_count_bound, phase_q == PH_DATA, cnt_q != len_q, "payload count overran size")

endmodule
